FILE: sv/vibration_rms_impact_detector_defines.svh
// Assertion macros for the vibration RMS impact detector.
`ifndef VIBRATION_RMS_IMPACT_DETECTOR_DEFINES_SVH
`define VIBRATION_RMS_IMPACT_DETECTOR_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define VRID_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define VRID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VRID_ASSERT_SAME(label, ante, cons, msg)
`define VRID_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/vrid_pkg.sv
// Package with the types, constants and codes of the vibration RMS impact detector.
package vrid_pkg;

	// Default length of the sliding window.
	localparam int WINDOW_DEFAULT = 20;

	// Field widths.
	localparam int AXIS_W = 16;
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 32;
	localparam int ONE_G_W = 15;
	localparam int THR_W  = 16;
	localparam int CNT_W  = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Iterative units: 16 root digits from a 32-bit radicand, 4 quotient bits per cycle.
	localparam int SQRT_STEPS = 16;
	localparam int DIV_BITS   = 4;
	localparam int ITER_W     = 4;
	localparam int REM_W      = 18;

	// Register reset values.
	localparam logic [ONE_G_W-1:0] ONE_G_RESET     = 15'd16384;
	localparam logic [THR_W-1:0]   MOVING_THR_RESET = 16'd1638;
	localparam logic [THR_W-1:0]   IMPACT_THR_RESET = 16'd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_G      = 2'd0,
		REG_MOVING_THR = 2'd1,
		REG_IMPACT_THR = 2'd2
	} vrid_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_MAG,
		ST_DELTA,
		ST_UPDATE,
		ST_DIVIDE,
		ST_ROOT_RMS,
		ST_DONE
	} vrid_state_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
	} vrid_in_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic [MAG_W-1:0] rms_level;
		logic             moving;
		logic             impact;
		logic [CNT_W-1:0] impact_total;
	} vrid_out_t;

	// Absolute value of a signed axis sample; -32768 maps to 32768.
	function automatic logic [AXIS_W-1:0] axis_abs(input logic signed [AXIS_W-1:0] a);
		logic [AXIS_W-1:0] r;
		r = a[AXIS_W-1] ? AXIS_W'(-a) : AXIS_W'(a);
		return r;
	endfunction

endpackage

FILE: sv/vrid_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface vrid_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/vibration_rms_impact_detector.sv
// Vibration RMS and impact detector: top level with sequencer, ring memory and shared units.
//
// The block takes one three-axis accelerometer sample per sample transaction and returns one
// result transaction per sample: the magnitude (floor square root of x*x + y*y + z*z), the
// vibration RMS (floor square root of the window sum of squared magnitude changes divided by
// WINDOW), a moving flag (magnitude more than the moving threshold away from one_g_counts), an
// impact flag (RMS above the impact threshold) and the running impact count, which wraps at
// 32 bits. The time a sample takes is set by the one shared 16-step square-root unit, which
// runs twice per sample, by the divide-by-WINDOW unit, which retires four quotient bits a
// cycle, and by the single shared multiplier, which forms the three axis squares and the
// squared change one after the other. One sample is worked on at a time; the next sample is
// taken as soon as the result sits in the output register, even if the consumer has not yet
// taken it. The squared changes live in a synchronous ring memory of WINDOW entries with a
// registered read; per-entry valid bits make every entry read as zero after reset, so no
// clearing pass is needed and the block is ready right after reset. Configuration writes are
// expected only while the block is idle.
module vibration_rms_impact_detector #(
	parameter int WINDOW = vrid_pkg::WINDOW_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vrid_stream_if.sink                   sample,
	vrid_stream_if.source                 result,
	input  logic                          cfg_we,
	input  logic [vrid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vrid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vrid_pkg::*;

	`include "vibration_rms_impact_detector_defines.svh"

	// Derived sizes. The window sum of WINDOW 32-bit squares needs clog2(WINDOW) extra bits.
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int SUM_W   = SQ_W + $clog2(WINDOW);
	localparam int DVS_W   = $clog2(WINDOW + 1);
	localparam int DIV_CYC = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W   = DIV_CYC * DIV_BITS;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [ONE_G_W-1:0] one_g_q;
	logic [THR_W-1:0]   moving_thr_q;
	logic [THR_W-1:0]   impact_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_g_q      <= ONE_G_RESET;
			moving_thr_q <= MOVING_THR_RESET;
			impact_thr_q <= IMPACT_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ONE_G:      one_g_q      <= cfg_data[ONE_G_W-1:0];
				REG_MOVING_THR: moving_thr_q <= cfg_data[THR_W-1:0];
				REG_IMPACT_THR: impact_thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	vrid_state_t state_q, state_next;
	logic [1:0]        axis_q;
	logic [ITER_W-1:0] iter_q;

	logic out_valid_q;
	logic out_load;
	logic take_sample;
	logic last_axis;
	logic last_root;
	logic last_div;

	assign take_sample = sample.valid && sample.ready;
	assign last_axis   = (axis_q == 2'd2);
	assign last_root   = (iter_q == ITER_W'(SQRT_STEPS - 1));
	assign last_div    = (iter_q == ITER_W'(DIV_CYC - 1));

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:     if (sample.valid) state_next = ST_SQUARE;
			ST_SQUARE:   if (last_axis) state_next = ST_ROOT_MAG;
			ST_ROOT_MAG: if (last_root) state_next = ST_DELTA;
			ST_DELTA:    state_next = ST_UPDATE;
			ST_UPDATE:   state_next = ST_DIVIDE;
			ST_DIVIDE:   if (last_div) state_next = ST_ROOT_RMS;
			ST_ROOT_RMS: if (last_root) state_next = ST_DONE;
			ST_DONE:     if (out_load) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == ST_IDLE);
		out_load     = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_SQUARE) begin
				axis_q <= last_axis ? 2'd0 : axis_q + 2'd1;
			end
			// The iteration count restarts whenever the sequencer moves on.
			if (state_next != state_q) begin
				iter_q <= '0;
			end else begin
				iter_q <= iter_q + ITER_W'(1);
			end
		end
	end

	// Accepted sample, held while it is worked on.
	vrid_in_t in_q;

	always_ff @(posedge clk) begin
		if (take_sample) begin
			in_q <= sample.payload;
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier: axis squares, then the squared magnitude change.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0]  mag_q;
	logic [MAG_W-1:0]  last_mag_q;
	logic [MAG_W-1:0]  delta;
	logic [AXIS_W-1:0] mul_op;
	logic [SQ_W-1:0]   product;
	logic [SQ_W-1:0]   dsq_q;

	// The root register holds the fresh magnitude during the delta state.
	logic [MAG_W-1:0] root_q;

	assign delta = (root_q >= last_mag_q) ? root_q - last_mag_q : last_mag_q - root_q;

	always_comb begin
		case (axis_q)
			2'd0:    mul_op = axis_abs(in_q.accel_x);
			2'd1:    mul_op = axis_abs(in_q.accel_y);
			default: mul_op = axis_abs(in_q.accel_z);
		endcase
		if (state_q == ST_DELTA) begin
			mul_op = delta;
		end
	end

	assign product = SQ_W'(mul_op) * SQ_W'(mul_op);

	// ------------------------------------------------------------------
	// Divide by WINDOW: restoring division, DIV_BITS quotient bits a cycle.
	// The remainder stays below WINDOW, so every compare is narrow.
	// ------------------------------------------------------------------
	logic [DIV_W-1:0] div_q;
	logic [DVS_W-1:0] div_rem_q;
	logic [DIV_W-1:0] div_next;
	logic [DVS_W-1:0] div_rem_next;
	// Updated window sum; the divider is loaded with it in the update state.
	logic [SUM_W-1:0] sum_new;

	always_comb begin
		logic [DVS_W:0]        trial;
		logic [DIV_BITS-1:0]   qbits;
		logic [DVS_W-1:0]      r;
		r = div_rem_q;
		qbits = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r, div_q[DIV_W-1-i]};
			if (trial >= (DVS_W+1)'(WINDOW)) begin
				r = DVS_W'(trial - (DVS_W+1)'(WINDOW));
				qbits[DIV_BITS-1-i] = 1'b1;
			end else begin
				r = DVS_W'(trial);
			end
		end
		div_rem_next = r;
		div_next     = {div_q[DIV_W-DIV_BITS-1:0], qbits};
	end

	// ------------------------------------------------------------------
	// Shared square-root unit: one result bit a cycle over a 32-bit radicand.
	// ------------------------------------------------------------------
	logic [SQ_W-1:0]  root_src_q;
	logic [REM_W-1:0] root_rem_q;
	logic [REM_W-1:0] root_rem_next;
	logic [MAG_W-1:0] root_next;

	always_comb begin
		logic [REM_W+1:0] rem_sh;
		logic [REM_W+1:0] trial;
		rem_sh = {root_rem_q, root_src_q[SQ_W-1:SQ_W-2]};
		trial  = (REM_W+2)'({root_q, 2'b01});
		if (rem_sh >= trial) begin
			root_rem_next = REM_W'(rem_sh - trial);
			root_next     = {root_q[MAG_W-2:0], 1'b1};
		end else begin
			root_rem_next = REM_W'(rem_sh);
			root_next     = {root_q[MAG_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_SQUARE: begin
				// The radicand register doubles as the sum of squares.
				root_src_q <= ((axis_q == 2'd0) ? '0 : root_src_q) + product;
				root_rem_q <= '0;
				root_q     <= '0;
			end
			ST_ROOT_MAG, ST_ROOT_RMS: begin
				root_src_q <= {root_src_q[SQ_W-3:0], 2'b00};
				root_rem_q <= root_rem_next;
				root_q     <= root_next;
			end
			ST_DELTA: begin
				dsq_q <= product;
				mag_q <= root_q;
			end
			ST_DIVIDE: begin
				div_q     <= div_next;
				div_rem_q <= div_rem_next;
				if (last_div) begin
					root_src_q <= div_next[SQ_W-1:0];
					root_rem_q <= '0;
					root_q     <= '0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_UPDATE) begin
			div_q     <= DIV_W'(sum_new);
			div_rem_q <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Ring memory of squared changes, running sum and write slot.
	// The slot address only moves in the update state, so the registered read
	// data at that state always belongs to the slot being replaced; the read taken in
	// the same cycle as the write to that entry is reloaded before it is used.
	// ------------------------------------------------------------------
	logic [SQ_W-1:0]   ring_mem [WINDOW];
	logic [SQ_W-1:0]   ring_rd_q;
	logic [WINDOW-1:0] ring_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   old_sq;
	logic              ring_we;

	assign ring_we = (state_q == ST_UPDATE);
	assign old_sq  = ring_valid_q[slot_q] ? ring_rd_q : '0;
	assign sum_new = sum_q - SUM_W'(old_sq) + SUM_W'(dsq_q);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= dsq_q;
		end
		ring_rd_q <= ring_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_valid_q <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			last_mag_q   <= '0;
		end else if (ring_we) begin
			ring_valid_q[slot_q] <= 1'b1;
			slot_q     <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			sum_q      <= sum_new;
			last_mag_q <= mag_q;
		end
	end

	// ------------------------------------------------------------------
	// Flags, impact count and output register.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] one_g_ext;
	logic [MAG_W-1:0] deviation;
	logic             moving;
	logic             impact;
	logic [CNT_W-1:0] impact_cnt_q;
	logic [CNT_W-1:0] impact_cnt_next;
	vrid_out_t        out_q;

	assign one_g_ext       = MAG_W'(one_g_q);
	assign deviation       = (mag_q >= one_g_ext) ? mag_q - one_g_ext : one_g_ext - mag_q;
	assign moving          = (deviation > moving_thr_q);
	assign impact          = (root_q > impact_thr_q);
	assign impact_cnt_next = impact_cnt_q + CNT_W'(impact);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			impact_cnt_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				impact_cnt_q <= impact_cnt_next;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.magnitude    <= mag_q;
			out_q.rms_level    <= root_q;
			out_q.moving       <= moving;
			out_q.impact       <= impact;
			out_q.impact_total <= impact_cnt_next;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`VRID_ASSERT_NEXT(a_busy_after_accept, take_sample, !sample.ready,
		"sample accepted but block still ready the next cycle")
	`VRID_ASSERT_SAME(a_load_into_free_reg, out_load, !out_valid_q || result.ready,
		"result loaded over an untaken result")
	`VRID_ASSERT_SAME(a_impact_matches_rms, result.valid,
		result.payload.impact == (result.payload.rms_level > impact_thr_q),
		"impact flag disagrees with RMS and threshold")

endmodule
